/* rtl/core/c2bg_pkg.sv */
// ----------------------------------------------------------------------------
// c2bg_pkg
// Shared types, sizes, codes and helpers of the convolution backward core.
// ----------------------------------------------------------------------------
package c2bg_pkg;

    localparam int MAX_BATCH    = 4;
    localparam int MAX_CHANNELS = 8;
    localparam int MAX_IN_DIM   = 32;
    localparam int MAX_KERNELS  = 16;
    localparam int MAX_K_DIM    = 7;

    localparam int ACT_DEPTH  = MAX_BATCH * MAX_CHANNELS * MAX_IN_DIM * MAX_IN_DIM;
    localparam int WGT_DEPTH  = MAX_KERNELS * MAX_CHANNELS * MAX_K_DIM * MAX_K_DIM;
    localparam int OG_DEPTH   = MAX_BATCH * MAX_KERNELS * MAX_IN_DIM * MAX_IN_DIM;
    localparam int BIAS_DEPTH = MAX_KERNELS;

    // wide accumulator, holds any exact sum of this configuration range
    localparam int ACC_W = 48;

    localparam logic [2:0] OP_LOAD_ACT = 3'd0;
    localparam logic [2:0] OP_LOAD_WGT = 3'd1;
    localparam logic [2:0] OP_LOAD_OG  = 3'd2;
    localparam logic [2:0] OP_COMPUTE  = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    localparam logic [1:0] RK_IN   = 2'd0;
    localparam logic [1:0] RK_KERN = 2'd1;
    localparam logic [1:0] RK_BIAS = 2'd2;
    localparam logic [1:0] RK_DONE = 2'd3;

    localparam logic [2:0] REG_IN_CH  = 3'd0;
    localparam logic [2:0] REG_IN_W   = 3'd1;
    localparam logic [2:0] REG_IN_H   = 3'd2;
    localparam logic [2:0] REG_KCOUNT = 3'd3;
    localparam logic [2:0] REG_KW     = 3'd4;
    localparam logic [2:0] REG_KH     = 3'd5;
    localparam logic [2:0] REG_STEP_X = 3'd6;
    localparam logic [2:0] REG_STEP_Y = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_G0,
        S_G1,
        S_G2,
        S_GRD,
        S_GBIAS,
        S_A0,
        S_A1,
        S_A2,
        S_RD,
        S_MUL,
        S_WR,
        S_CDONE,
        S_RDATA,
        S_DIV,
        S_ROUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] hi;
        hi = v[ACC_W-1:31];
        if ((&hi) || (~|hi)) begin
            return v[31:0];
        end else if (v[ACC_W-1]) begin
            return 32'sh8000_0000;
        end
        return 32'sh7fff_ffff;
    endfunction

endpackage

/* rtl/core/conv2d_backward_gradients_core.sv */
// ----------------------------------------------------------------------------
// conv2d_backward_gradients_core
// Strided 2D convolution backward pass over on-chip stores: input, kernel and
// bias gradients in Q8.24 from Q4.12 activations, weights and output gradients.
// ----------------------------------------------------------------------------
//  channel | signals                          | role
//  --------+----------------------------------+------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tuser | load / compute / read items
//  m_      | m_tvalid m_tready m_tdata m_tuser | read results, compute done
//  cfg_    | cfg_valid cfg_ready cfg_index     | register writes
//          | cfg_data                          |
//
//  loads are written straight into the stores, back to back while idle.
//  compute: a clearing pass over the gradient stores, then per output position
//  the states G0 to GBIAS plus per kernel tap A0 to WR (read, multiply, write
//  back), then done. reads: kernel and bias gradients go through the bit-serial
//  batch divider, input gradients do not. no clearing pass after reset.
//  the input side is taken in idle even while a result waits on m_tready.
// ----------------------------------------------------------------------------
module conv2d_backward_gradients_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // opcode[2:0] elem_index[18:3] elem_value[34:19]
                                   // batch_count[37:35] zero[39:38]
    input  logic [1:0]  s_tuser,   // read_kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_index[15:0] result_value[47:16]
    output logic [2:0]  m_tuser,   // result_kind[1:0] done_res[2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import c2bg_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [3:0] cin_reg;
    logic [5:0] w_reg, h_reg;
    logic [4:0] kc_reg;
    logic [2:0] kw_reg, kh_reg, sx_reg, sy_reg;
    logic [3:0] cc;
    logic [5:0] ww, hh;
    logic [4:0] kk;
    logic [2:0] kwc, khc, sxc, syc;

    // input decode
    logic [2:0]         s_op;
    logic [15:0]        s_idx;
    logic signed [15:0] s_val;
    logic [2:0]         s_batch;
    logic               s_acc;

    // walk
    logic [2:0]  nb_reg;
    logic        computed_reg;
    logic [14:0] clr_reg;
    logic [5:0]  ow_reg, oh_reg, ow_rem_reg, oh_rem_reg;
    logic        ow_zero_reg, oh_zero_reg;
    logic [1:0]  n_reg;
    logic [3:0]  k_reg;
    logic [4:0]  oy_reg, ox_reg;
    logic [2:0]  c_reg, ky_reg, kx_reg;
    logic [4:0]  y_reg, x_reg, t1_reg;
    logic [6:0]  t2_reg;
    logic [9:0]  u1_reg, u2_reg;
    logic [14:0] ai_reg;
    logic [12:0] wi_reg;
    logic [5:0]  tg_reg;
    logic [10:0] ug_reg;
    logic [15:0] gi_reg;
    logic signed [15:0] g_reg;
    logic signed [31:0] prod_in_reg, prod_k_reg;
    logic tap_last, pos_last;

    // stores
    logic signed [15:0]      act_mem [ACT_DEPTH];
    logic signed [15:0]      wgt_mem [WGT_DEPTH];
    logic signed [15:0]      og_mem  [OG_DEPTH];
    logic signed [ACC_W-1:0] ig_mem  [ACT_DEPTH];
    logic signed [ACC_W-1:0] kg_mem  [WGT_DEPTH];
    logic signed [ACC_W-1:0] bias_reg [BIAS_DEPTH];
    logic signed [15:0]      act_rd_reg, wgt_rd_reg, og_rd_reg;
    logic signed [ACC_W-1:0] ig_rd_reg, kg_rd_reg;
    logic [14:0]             ig_addr;
    logic [12:0]             kg_addr;
    logic                    ig_we, kg_we;
    logic signed [ACC_W-1:0] ig_wdata, kg_wdata;

    // read path
    logic [15:0]             idx_reg;
    logic [1:0]              rk_reg;
    logic                    rd_ok;
    logic signed [ACC_W-1:0] val_reg;
    logic                    div_start, div_done;
    logic signed [ACC_W-1:0] div_q;

    // output register
    logic               out_valid_reg;
    logic [1:0]         out_kind_reg;
    logic [15:0]        out_idx_reg;
    logic signed [31:0] out_val_reg;
    logic               out_done_reg;
    logic               out_free, out_load;

    assign s_op    = s_tdata[2:0];
    assign s_idx   = s_tdata[18:3];
    assign s_val   = s_tdata[34:19];
    assign s_batch = s_tdata[37:35];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        cc  = (cin_reg == 4'd0) ? 4'd1 : ((cin_reg > 4'(MAX_CHANNELS)) ?
              4'(MAX_CHANNELS) : cin_reg);
        ww  = (w_reg == 6'd0) ? 6'd1 : ((w_reg > 6'(MAX_IN_DIM)) ? 6'(MAX_IN_DIM) : w_reg);
        hh  = (h_reg == 6'd0) ? 6'd1 : ((h_reg > 6'(MAX_IN_DIM)) ? 6'(MAX_IN_DIM) : h_reg);
        kk  = (kc_reg == 5'd0) ? 5'd1 : ((kc_reg > 5'(MAX_KERNELS)) ?
              5'(MAX_KERNELS) : kc_reg);
        kwc = (kw_reg == 3'd0) ? 3'd1 : kw_reg;
        khc = (kh_reg == 3'd0) ? 3'd1 : kh_reg;
        sxc = (sx_reg == 3'd0) ? 3'd1 : sx_reg;
        syc = (sy_reg == 3'd0) ? 3'd1 : sy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cin_reg <= 4'd1;
            w_reg   <= 6'd32;
            h_reg   <= 6'd32;
            kc_reg  <= 5'd1;
            kw_reg  <= 3'd3;
            kh_reg  <= 3'd3;
            sx_reg  <= 3'd1;
            sy_reg  <= 3'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IN_CH:  cin_reg <= cfg_data[3:0];
                REG_IN_W:   w_reg   <= cfg_data[5:0];
                REG_IN_H:   h_reg   <= cfg_data[5:0];
                REG_KCOUNT: kc_reg  <= cfg_data[4:0];
                REG_KW:     kw_reg  <= cfg_data[2:0];
                REG_KH:     kh_reg  <= cfg_data[2:0];
                REG_STEP_X: sx_reg  <= cfg_data[2:0];
                REG_STEP_Y: sy_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign tap_last = (4'(kx_reg) + 4'd1 >= {1'b0, kwc}) &&
                      (4'(ky_reg) + 4'd1 >= {1'b0, khc}) &&
                      (4'(c_reg) + 4'd1 >= cc);
    assign pos_last = (6'(ox_reg) + 6'd1 >= ow_reg) && (6'(oy_reg) + 6'd1 >= oh_reg) &&
                      (5'(k_reg) + 5'd1 >= kk) && (3'(n_reg) + 3'd1 >= nb_reg);

    always_comb begin
        case (rk_reg)
            RK_IN:   rd_ok = computed_reg && !idx_reg[15];
            RK_KERN: rd_ok = computed_reg && (idx_reg < 16'(WGT_DEPTH));
            RK_BIAS: rd_ok = computed_reg && (idx_reg < 16'(BIAS_DEPTH));
            default: rd_ok = 1'b0;
        endcase
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = out_free && ((state_reg == S_CDONE) || (state_reg == S_ROUT));
    assign div_start = (state_reg == S_RDATA) && (rk_reg != RK_IN) && rd_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc && (s_op == OP_COMPUTE)) begin
                    state_next = S_CLEAR;
                end else if (s_acc && (s_op == OP_READ) && (s_tuser != RK_DONE)) begin
                    // kind three has no store and is dropped
                    state_next = S_RDATA;
                end
            end
            S_CLEAR: begin
                if (clr_reg == 15'(ACT_DEPTH - 1)) begin
                    state_next = (ow_zero_reg || oh_zero_reg) ? S_CDONE : S_G0;
                end
            end
            S_G0:    state_next = S_G1;
            S_G1:    state_next = S_G2;
            S_G2:    state_next = S_GRD;
            S_GRD:   state_next = S_GBIAS;
            S_GBIAS: state_next = S_A0;
            S_A0:    state_next = S_A1;
            S_A1:    state_next = S_A2;
            S_A2:    state_next = S_RD;
            S_RD:    state_next = S_MUL;
            S_MUL:   state_next = S_WR;
            S_WR: begin
                if (!tap_last) begin
                    state_next = S_A0;
                end else begin
                    state_next = pos_last ? S_CDONE : S_G0;
                end
            end
            S_CDONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_RDATA: state_next = div_start ? S_DIV : S_ROUT;
            S_DIV: begin
                if (div_done) begin
                    state_next = S_ROUT;
                end
            end
            S_ROUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            computed_reg <= 1'b0;
        end else if (s_acc && (s_op == OP_COMPUTE)) begin
            computed_reg <= 1'b1;
        end
    end

    // walk counters, index arithmetic and operands
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                clr_reg <= '0;
                idx_reg <= s_idx;
                rk_reg  <= s_tuser;
                if (s_acc && (s_op == OP_COMPUTE)) begin
                    nb_reg <= (s_batch == 3'd0) ? 3'd1 :
                              ((s_batch > 3'(MAX_BATCH)) ? 3'(MAX_BATCH) : s_batch);
                    ow_reg <= 6'd1;
                    oh_reg <= 6'd1;
                    ow_zero_reg <= (ww < 6'(kwc));
                    oh_zero_reg <= (hh < 6'(khc));
                    ow_rem_reg  <= (ww < 6'(kwc)) ? 6'd0 : ww - 6'(kwc);
                    oh_rem_reg  <= (hh < 6'(khc)) ? 6'd0 : hh - 6'(khc);
                    for (int i = 0; i < BIAS_DEPTH; i++) begin
                        bias_reg[i] <= '0;
                    end
                end
            end
            S_CLEAR: begin
                clr_reg <= clr_reg + 1'b1;
                // output size by repeated subtraction of the stride
                if (ow_rem_reg >= 6'(sxc)) begin
                    ow_rem_reg <= ow_rem_reg - 6'(sxc);
                    ow_reg     <= ow_reg + 1'b1;
                end
                if (oh_rem_reg >= 6'(syc)) begin
                    oh_rem_reg <= oh_rem_reg - 6'(syc);
                    oh_reg     <= oh_reg + 1'b1;
                end
                n_reg  <= '0;
                k_reg  <= '0;
                oy_reg <= '0;
                ox_reg <= '0;
            end
            S_G0: begin
                tg_reg <= 6'(n_reg) * 6'(kk) + 6'(k_reg);
                c_reg  <= '0;
                ky_reg <= '0;
                kx_reg <= '0;
            end
            S_G1: ug_reg <= 11'(tg_reg) * 11'(oh_reg) + 11'(oy_reg);
            S_G2: gi_reg <= 16'(ug_reg) * 16'(ow_reg) + 16'(ox_reg);
            S_GBIAS: begin
                g_reg <= og_rd_reg;
                bias_reg[k_reg] <= bias_reg[k_reg] + (ACC_W'(og_rd_reg) <<< 12);
            end
            S_A0: begin
                y_reg  <= 5'(oy_reg) * 5'(syc) + 5'(ky_reg);
                x_reg  <= 5'(ox_reg) * 5'(sxc) + 5'(kx_reg);
                t1_reg <= 5'(n_reg) * 5'(cc) + 5'(c_reg);
                t2_reg <= 7'(k_reg) * 7'(cc) + 7'(c_reg);
            end
            S_A1: begin
                u1_reg <= 10'(t1_reg) * 10'(hh) + 10'(y_reg);
                u2_reg <= 10'(t2_reg) * 10'(khc) + 10'(ky_reg);
            end
            S_A2: begin
                ai_reg <= 15'(u1_reg) * 15'(ww) + 15'(x_reg);
                wi_reg <= 13'(u2_reg) * 13'(kwc) + 13'(kx_reg);
            end
            S_MUL: begin
                prod_in_reg <= wgt_rd_reg * g_reg;
                prod_k_reg  <= act_rd_reg * g_reg;
            end
            S_WR: begin
                if (4'(kx_reg) + 4'd1 < {1'b0, kwc}) begin
                    kx_reg <= kx_reg + 1'b1;
                end else if (4'(ky_reg) + 4'd1 < {1'b0, khc}) begin
                    kx_reg <= '0;
                    ky_reg <= ky_reg + 1'b1;
                end else if (4'(c_reg) + 4'd1 < cc) begin
                    kx_reg <= '0;
                    ky_reg <= '0;
                    c_reg  <= c_reg + 1'b1;
                end else if (6'(ox_reg) + 6'd1 < ow_reg) begin
                    ox_reg <= ox_reg + 1'b1;
                end else if (6'(oy_reg) + 6'd1 < oh_reg) begin
                    ox_reg <= '0;
                    oy_reg <= oy_reg + 1'b1;
                end else if (5'(k_reg) + 5'd1 < kk) begin
                    ox_reg <= '0;
                    oy_reg <= '0;
                    k_reg  <= k_reg + 1'b1;
                end else begin
                    ox_reg <= '0;
                    oy_reg <= '0;
                    k_reg  <= '0;
                    n_reg  <= n_reg + 1'b1;
                end
            end
            S_RDATA: begin
                if (rk_reg == RK_IN) begin
                    val_reg <= rd_ok ? ig_rd_reg : '0;
                end else begin
                    val_reg <= '0;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    val_reg <= div_q;
                end
            end
            default: ;
        endcase
    end

    // load stores
    always_ff @(posedge aclk) begin
        if (s_acc && (s_op == OP_LOAD_ACT) && !s_idx[15]) begin
            act_mem[s_idx[14:0]] <= s_val;
        end
        act_rd_reg <= act_mem[ai_reg];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && (s_op == OP_LOAD_WGT) && (s_idx < 16'(WGT_DEPTH))) begin
            wgt_mem[s_idx[12:0]] <= s_val;
        end
        wgt_rd_reg <= wgt_mem[wi_reg];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && (s_op == OP_LOAD_OG)) begin
            og_mem[s_idx] <= s_val;
        end
        og_rd_reg <= og_mem[gi_reg];
    end

    // gradient accumulators: read, add, write back
    always_comb begin
        case (state_reg)
            S_IDLE:  ig_addr = s_idx[14:0];
            S_CLEAR: ig_addr = clr_reg;
            default: ig_addr = ai_reg;
        endcase
        case (state_reg)
            S_IDLE:  kg_addr = s_idx[12:0];
            S_CLEAR: kg_addr = clr_reg[12:0];
            default: kg_addr = wi_reg;
        endcase
        ig_we    = (state_reg == S_CLEAR) || (state_reg == S_WR);
        kg_we    = ((state_reg == S_CLEAR) && (clr_reg < 15'(WGT_DEPTH))) ||
                   (state_reg == S_WR);
        ig_wdata = (state_reg == S_CLEAR) ? '0 : ig_rd_reg + ACC_W'(prod_in_reg);
        kg_wdata = (state_reg == S_CLEAR) ? '0 : kg_rd_reg + ACC_W'(prod_k_reg);
    end

    always_ff @(posedge aclk) begin
        if (ig_we) begin
            ig_mem[ig_addr] <= ig_wdata;
        end
        ig_rd_reg <= ig_mem[ig_addr];
    end

    always_ff @(posedge aclk) begin
        if (kg_we) begin
            kg_mem[kg_addr] <= kg_wdata;
        end
        kg_rd_reg <= kg_mem[kg_addr];
    end

    c2bg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ((rk_reg == RK_KERN) ? kg_rd_reg : bias_reg[idx_reg[3:0]]),
        .divisor  (nb_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // result register, decouples the walk from m_tready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (state_reg == S_CDONE) begin
                out_kind_reg <= RK_DONE;
                out_idx_reg  <= '0;
                out_val_reg  <= '0;
                out_done_reg <= 1'b1;
            end else begin
                out_kind_reg <= rk_reg;
                out_idx_reg  <= idx_reg;
                out_val_reg  <= sat32(val_reg);
                out_done_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_val_reg, out_idx_reg};
    assign m_tuser  = {out_done_reg, out_kind_reg};

    a_cmp_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_op == OP_COMPUTE)) |=> (state_reg == S_CLEAR))
        else $error("compute transfer did not start the clearing pass");

    a_div_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> ((rk_reg == RK_KERN) || (rk_reg == RK_BIAS)))
        else $error("divider running for an input gradient read");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> ((m_tdata == '0) && (m_tuser[1:0] == RK_DONE)))
        else $error("compute done result carries data");

endmodule

/* rtl/core/c2bg_div.sv */
// ----------------------------------------------------------------------------
// c2bg_div
// Restoring divider of a signed accumulator by a small batch count, one
// quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module c2bg_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [c2bg_pkg::ACC_W-1:0]  dividend,
    input  logic        [2:0]                  divisor,
    output logic                               done,
    output logic signed [c2bg_pkg::ACC_W-1:0]  quotient
);
    import c2bg_pkg::*;

    localparam int CNT_W = $clog2(ACC_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0] mag_reg;
    logic [2:0]       rem_reg;
    logic [2:0]       d_reg;
    logic             neg_reg;
    logic [3:0]       sh;
    logic             fits;

    always_comb begin
        sh   = {rem_reg, mag_reg[ACC_W-1]};
        fits = (sh >= {1'b0, d_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == CNT_W'(ACC_W - 1))) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            neg_reg <= dividend[ACC_W-1];
            d_reg   <= divisor;
            rem_reg <= 3'd0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? 3'(sh - {1'b0, d_reg}) : sh[2:0];
            mag_reg <= {mag_reg[ACC_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the convolution backward core. Loads, computes and
// result reads are driven over the input stream, and every result transfer is
// compared with a local gradient predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import c2bg_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int IDLE_GUARD  = 64;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [1:0]         kind;
        logic [15:0]        index;
        logic signed [31:0] value;
        logic               done;
    } grad_res_t;

    typedef struct {
        logic [2:0]         op;
        logic [15:0]        index;
        logic [15:0]        value;
        logic [1:0]         kind;
        logic [2:0]         batch;
        bit                 typed;
        logic signed [31:0] exp_value;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // opcode elem_index elem_value batch_count zero
    logic [1:0]  s_tuser = '0;   // read_kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // result_index result_value
    logic [2:0]  m_tuser;        // result_kind done_res
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    conv2d_backward_gradients_core i_dut (.*);

    // predictor state
    logic [7:0]         cfg_reg [8];
    logic signed [15:0] act_mem [ACT_DEPTH];
    logic signed [15:0] wgt_mem [WGT_DEPTH];
    logic signed [15:0] og_mem  [OG_DEPTH];
    logic signed [31:0] in_grad  [ACT_DEPTH];
    logic signed [31:0] kern_grad[WGT_DEPTH];
    logic signed [31:0] bias_grad[BIAS_DEPTH];
    longint             acc_in  [ACT_DEPTH];
    longint             acc_kern[WGT_DEPTH];
    longint             acc_bias[BIAS_DEPTH];
    bit                 act_wr [ACT_DEPTH];
    bit                 wgt_wr [WGT_DEPTH];
    bit                 og_wr  [OG_DEPTH];

    grad_res_t pending_grads[$];
    int        items_sent;
    int        results_seen;
    int        mismatches;
    bit        quiet;
    int        cycles;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL conv2d_backward_gradients_core");
            $finish;
        end
    end

    function automatic int clip(longint v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void run_backward(logic [2:0] braw);
        int nb, nc, wd, ht, nk, kw, kh, sx, sy, ow, oh, y, x, ai, wi, gi;
        longint g;
        nb = clip(longint'(braw), MAX_BATCH);
        nc = clip(longint'(cfg_reg[REG_IN_CH]), MAX_CHANNELS);
        wd = clip(longint'(cfg_reg[REG_IN_W]), MAX_IN_DIM);
        ht = clip(longint'(cfg_reg[REG_IN_H]), MAX_IN_DIM);
        nk = clip(longint'(cfg_reg[REG_KCOUNT]), MAX_KERNELS);
        kw = clip(longint'(cfg_reg[REG_KW]), MAX_K_DIM);
        kh = clip(longint'(cfg_reg[REG_KH]), MAX_K_DIM);
        sx = clip(longint'(cfg_reg[REG_STEP_X]), 7);
        sy = clip(longint'(cfg_reg[REG_STEP_Y]), 7);
        ow = (wd >= kw) ? (wd - kw) / sx + 1 : 0;
        oh = (ht >= kh) ? (ht - kh) / sy + 1 : 0;
        foreach (acc_in[i]) acc_in[i] = 0;
        foreach (acc_kern[i]) acc_kern[i] = 0;
        foreach (acc_bias[i]) acc_bias[i] = 0;
        for (int n = 0; n < nb; n++)
            for (int k = 0; k < nk; k++)
                for (int oy = 0; oy < oh; oy++)
                    for (int ox = 0; ox < ow; ox++) begin
                        gi = ((n * nk + k) * oh + oy) * ow + ox;
                        g = (gi < OG_DEPTH) ? longint'(og_mem[gi]) : 0;
                        acc_bias[k] += g * 4096;
                        for (int c = 0; c < nc; c++)
                            for (int ky = 0; ky < kh; ky++)
                                for (int kx = 0; kx < kw; kx++) begin
                                    y = oy * sy + ky;
                                    x = ox * sx + kx;
                                    if (y < ht && x < wd) begin
                                        ai = ((n * nc + c) * ht + y) * wd + x;
                                        wi = ((k * nc + c) * kh + ky) * kw + kx;
                                        if (ai < ACT_DEPTH && wi < WGT_DEPTH) begin
                                            acc_in[ai] += longint'(wgt_mem[wi]) * g;
                                            acc_kern[wi] += longint'(act_mem[ai]) * g;
                                        end
                                    end
                                end
                    end
        foreach (in_grad[i]) in_grad[i] = clip32(acc_in[i]);
        foreach (kern_grad[i]) kern_grad[i] = clip32(acc_kern[i] / longint'(nb));
        foreach (bias_grad[i]) bias_grad[i] = clip32(acc_bias[i] / longint'(nb));
    endfunction

    function automatic bit predict_grad(logic [2:0] op, logic [15:0] idx,
                                        logic [15:0] val, logic [1:0] kind,
                                        logic [2:0] batch, output grad_res_t r);
        int i;
        i = int'(idx);
        r = '{kind: kind, index: idx, value: '0, done: 1'b0};
        case (op)
            OP_LOAD_ACT: begin
                if (i < ACT_DEPTH) begin act_mem[i] = val; act_wr[i] = 1; end
                return 0;
            end
            OP_LOAD_WGT: begin
                if (i < WGT_DEPTH) begin wgt_mem[i] = val; wgt_wr[i] = 1; end
                return 0;
            end
            OP_LOAD_OG: begin
                if (i < OG_DEPTH) begin og_mem[i] = val; og_wr[i] = 1; end
                return 0;
            end
            OP_COMPUTE: begin
                run_backward(batch);
                r = '{kind: RK_DONE, index: '0, value: '0, done: 1'b1};
                return 1;
            end
            OP_READ: begin
                case (kind)
                    RK_IN:   if (i < ACT_DEPTH) r.value = in_grad[i];
                    RK_KERN: if (i < WGT_DEPTH) r.value = kern_grad[i];
                    RK_BIAS: if (i < BIAS_DEPTH) r.value = bias_grad[i];
                    default: return 0;
                endcase
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic send_item(logic [2:0] op, logic [15:0] idx, logic [15:0] val,
                             logic [1:0] kind, logic [2:0] batch,
                             bit typed = 0, logic signed [31:0] exp_value = '0);
        grad_res_t r;
        quiet = (items_sent >= 650);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, batch, val, idx, op};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        if (predict_grad(op, idx, val, kind, batch, r)) begin
            if (typed) r.value = exp_value;
            pending_grads = {pending_grads, r};
        end
        items_sent++;
    endtask

    // drain results, then let loads still in flight settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_grads.size() != 0) @(posedge aclk);
        repeat (IDLE_GUARD) @(posedge aclk);
    endtask

    task automatic set_regs(logic [7:0] vals [8]);
        logic [7:0] mask [8];
        mask = '{8'h0f, 8'h3f, 8'h3f, 8'h1f, 8'h07, 8'h07, 8'h07, 8'h07};
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            cfg_reg[i] = vals[i] & mask[i];
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_value(bit sharp);
        if (sharp || $urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        return 16'($urandom_range(0, 16'hffff));
    endfunction

    // ignored or stray items mixed into well-formed load and read sequences
    task automatic maybe_noise();
        logic [15:0] v;
        v = 16'($urandom_range(0, 16'hffff));
        if ($urandom_range(0, 9) != 0) return;
        case ($urandom_range(0, 4))
            0: send_item(3'($urandom_range(5, 7)), v, 16'($urandom_range(0, 16'hffff)),
                         2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            1: send_item(OP_READ, v, v, RK_DONE, 3'd0);
            2: send_item(OP_LOAD_ACT, 16'($urandom_range(ACT_DEPTH, 16'hffff)), v,
                         2'd0, 3'd0);
            3: send_item(OP_LOAD_WGT, 16'($urandom_range(WGT_DEPTH, 16'hffff)), v,
                         2'd0, 3'd0);
            default: send_item(OP_READ, v, v, 2'($urandom_range(0, 2)), 3'd0);
        endcase
    endtask

    task automatic run_phase(logic [7:0] vals [8], bit sharp, int reads);
        int nb, nc, wd, ht, nk, kw, kh, sx, sy, ow, oh, idx, lim;
        logic [2:0] braw;
        logic [1:0] kind;
        set_regs(vals);
        braw = 3'($urandom_range(0, 7));
        nb = clip(longint'(braw), MAX_BATCH);
        nc = clip(longint'(cfg_reg[REG_IN_CH]), MAX_CHANNELS);
        wd = clip(longint'(cfg_reg[REG_IN_W]), MAX_IN_DIM);
        ht = clip(longint'(cfg_reg[REG_IN_H]), MAX_IN_DIM);
        nk = clip(longint'(cfg_reg[REG_KCOUNT]), MAX_KERNELS);
        kw = clip(longint'(cfg_reg[REG_KW]), MAX_K_DIM);
        kh = clip(longint'(cfg_reg[REG_KH]), MAX_K_DIM);
        sx = clip(longint'(cfg_reg[REG_STEP_X]), 7);
        sy = clip(longint'(cfg_reg[REG_STEP_Y]), 7);
        ow = (wd >= kw) ? (wd - kw) / sx + 1 : 0;
        oh = (ht >= kh) ? (ht - kh) / sy + 1 : 0;
        // fill every entry the walk will touch, refresh some of the rest
        if (ow > 0 && oh > 0) begin
            for (idx = 0; idx < nb * nc * ht * wd; idx++)
                if (!act_wr[idx] || sharp || $urandom_range(0, 3) == 0) begin
                    maybe_noise();
                    send_item(OP_LOAD_ACT, idx[15:0], pick_value(sharp), 2'd0, 3'd0);
                end
            for (idx = 0; idx < nk * nc * kh * kw; idx++)
                if (!wgt_wr[idx] || sharp || $urandom_range(0, 3) == 0) begin
                    maybe_noise();
                    send_item(OP_LOAD_WGT, idx[15:0], pick_value(sharp), 2'd0, 3'd0);
                end
        end
        for (idx = 0; idx < nb * nk * oh * ow; idx++)
            if (!og_wr[idx] || sharp || $urandom_range(0, 3) == 0) begin
                maybe_noise();
                send_item(OP_LOAD_OG, idx[15:0], pick_value(sharp), 2'd0, 3'd0);
            end
        send_item(OP_COMPUTE, 16'($urandom_range(0, 16'hffff)),
                  16'($urandom_range(0, 16'hffff)), 2'($urandom_range(0, 3)), braw);
        for (int r = 0; r < reads; r++) begin
            kind = 2'($urandom_range(0, 2));
            lim = (kind == RK_IN) ? nb * nc * ht * wd :
                  (kind == RK_KERN) ? nk * nc * kh * kw : nk;
            if ($urandom_range(0, 7) == 0)
                idx = $urandom_range(0, 16'hffff);
            else
                idx = $urandom_range(0, lim - 1);
            maybe_noise();
            send_item(OP_READ, idx[15:0], 16'($urandom_range(0, 16'hffff)), kind,
                      3'($urandom_range(0, 7)));
        end
        wait_drained();
    endtask

    // result side: random stalls, one long hold-off to back the core up
    initial begin
        grad_res_t want;
        bit held;
        logic signed [31:0] got_value;
        held = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got_value = m_tdata[47:16];
                results_seen++;
                if (pending_grads.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: kind %0d index %0d value %0d",
                                 m_tuser[1:0], m_tdata[15:0], got_value);
                end else begin
                    want = pending_grads.pop_front();
                    if (want.kind !== m_tuser[1:0] || want.index !== m_tdata[15:0] ||
                        want.value !== got_value || want.done !== m_tuser[2]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp kind %0d index %0d value %0d done %0d,",
                                     want.kind, want.index, want.value, want.done,
                                     " got kind %0d index %0d value %0d done %0d",
                                     m_tuser[1:0], m_tdata[15:0], got_value, m_tuser[2]);
                    end
                end
            end
            if (!held && results_seen >= 30) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        dir_row_t   rows [20];
        logic [7:0] vals [8];
        int         phases;
        rows = '{
            '{OP_LOAD_ACT, 16'd0,     16'h7fff, RK_IN,   3'd0, 0, 32'sh0},
            '{OP_LOAD_WGT, 16'd0,     16'h8000, RK_IN,   3'd0, 0, 32'sh0},
            '{OP_LOAD_OG,  16'd0,     16'h8000, RK_IN,   3'd0, 0, 32'sh0},
            '{OP_LOAD_ACT, 16'd40000, 16'h1234, RK_IN,   3'd0, 0, 32'sh0},
            '{OP_LOAD_WGT, 16'hffff,  16'h0005, RK_IN,   3'd0, 0, 32'sh0},
            '{3'd5,        16'd0,     16'hffff, RK_KERN, 3'd1, 0, 32'sh0},
            '{3'd6,        16'hffff,  16'h0000, RK_BIAS, 3'd7, 0, 32'sh0},
            '{3'd7,        16'h8000,  16'h8000, RK_DONE, 3'd4, 0, 32'sh0},
            // batch of zero counts as one
            '{OP_COMPUTE,  16'd0,     16'h0000, RK_IN,   3'd0, 1, 32'sh0},
            '{OP_READ,     16'd0,     16'h0000, RK_IN,   3'd0, 1, 32'sh4000_0000},
            '{OP_READ,     16'd0,     16'h0000, RK_KERN, 3'd0, 1, 32'shc000_8000},
            '{OP_READ,     16'd0,     16'h0000, RK_BIAS, 3'd0, 1, 32'shf800_0000},
            '{OP_READ,     16'd0,     16'h0000, RK_DONE, 3'd0, 0, 32'sh0},
            '{OP_READ,     16'hffff,  16'h0000, RK_IN,   3'd0, 1, 32'sh0},
            '{OP_READ,     16'd6272,  16'h0000, RK_KERN, 3'd0, 1, 32'sh0},
            '{OP_READ,     16'd16,    16'h0000, RK_BIAS, 3'd0, 1, 32'sh0},
            '{OP_READ,     16'd1,     16'h0000, RK_IN,   3'd0, 1, 32'sh0},
            '{OP_LOAD_OG,  16'hffff,  16'h7fff, RK_IN,   3'd0, 0, 32'sh0},
            '{OP_COMPUTE,  16'd0,     16'h0000, RK_IN,   3'd1, 1, 32'sh0},
            '{OP_READ,     16'd0,     16'h0000, RK_KERN, 3'd0, 0, 32'sh0}
        };
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all zero: every size clamps to one, strides of zero count as one
        vals = '{default: 8'd0};
        set_regs(vals);
        foreach (rows[i])
            send_item(rows[i].op, rows[i].index, rows[i].value, rows[i].kind,
                      rows[i].batch, rows[i].typed, rows[i].exp_value);
        wait_drained();

        // largest settings; kernel taller than input leaves nothing to sum
        vals = '{8'd15, 8'd63, 8'd1, 8'd31, 8'd7, 8'd7, 8'd7, 8'd7};
        run_phase(vals, 0, 12);

        // full-scale operands drive the sums into saturation
        vals = '{8'd1, 8'd2, 8'd1, 8'd4, 8'd1, 8'd1, 8'd1, 8'd1};
        run_phase(vals, 1, 16);

        phases = 0;
        while (items_sent < 750 && phases < 10) begin
            vals[REG_IN_CH]  = 8'($urandom_range(1, 2));
            vals[REG_IN_W]   = 8'($urandom_range(1, 6));
            vals[REG_IN_H]   = 8'($urandom_range(1, 6));
            vals[REG_KCOUNT] = 8'($urandom_range(1, 3));
            vals[REG_KW]     = 8'($urandom_range(1, 3));
            vals[REG_KH]     = 8'($urandom_range(1, 3));
            vals[REG_STEP_X] = 8'($urandom_range(0, 3));
            vals[REG_STEP_Y] = 8'($urandom_range(0, 3));
            run_phase(vals, 0, 40);
            phases++;
        end

        while (pending_grads.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS conv2d_backward_gradients_core");
        end else begin
            $display("FAIL conv2d_backward_gradients_core");
        end
        $finish;
    end

endmodule
